>>> rtl/sbf_pkg.sv
// ----------------------------------------------------------------------------
// sbf_pkg: shared types and constants of the string Bloom filter
// Hash seeds and multipliers, the command queue depth, and queue status type.
// ----------------------------------------------------------------------------
package sbf_pkg;

   // Hash seeds and FNV-1a prime
   localparam logic [31:0] SEED_A    = 32'd5381;
   localparam logic [31:0] SEED_B    = 32'd0;
   localparam logic [31:0] SEED_C    = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   // Whitespace and case folding codes
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   // Command queue between hash front and bit engine
   localparam int CMD_DEPTH = 4;

   // Operation codes
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

endpackage

>>> rtl/sbf_ram.sv
// ----------------------------------------------------------------------------
// sbf_ram: generic single-clock RAM
// One write port and one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module sbf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/sbf_hash_front.sv
// ----------------------------------------------------------------------------
// sbf_hash_front: key normalization and running hashes
// Folds case, trims whitespace, runs djb2, times-31 and FNV-1a hashes one byte
// per accepted cycle; at key end it emits a command with three bit positions.
// ----------------------------------------------------------------------------
module sbf_hash_front #(
   parameter int INDEX_BITS = 19
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    func,
   input  logic [7:0]              key_byte,
   input  logic                    has_byte,
   input  logic                    last,
   output logic                    cmd_push,
   output logic [3*INDEX_BITS:0]   cmd_data
);
   import sbf_pkg::*;

   logic [31:0] run_a_ff, run_b_ff, run_c_ff;
   logic [31:0] run_a_in, run_b_in, run_c_in;
   logic [31:0] kept_a_ff, kept_b_ff, kept_c_ff;
   logic [31:0] kept_a_in, kept_b_in, kept_c_in;
   logic        seen_ff, seen_in;
   logic [7:0]  low_byte;
   logic [31:0] chr;
   logic [31:0] fnv_mix;
   logic        is_sp;
   logic        upd;
   logic        keep;

   // Case folding, whitespace detect, sign extension
   always_comb begin
      low_byte = key_byte;
      if (key_byte >= CH_UPPER_A && key_byte <= CH_UPPER_Z) begin
         low_byte = key_byte | CASE_BIT;
      end
      is_sp = (low_byte == CH_SPACE) || (low_byte == CH_TAB) ||
              (low_byte == CH_CR) || (low_byte == CH_LF);
      chr   = {{24{low_byte[7]}}, low_byte};
   end

   // Hash step: leading whitespace is skipped, trailing is undone via kept copy
   assign upd     = has_byte && (!is_sp || seen_ff);
   assign keep    = has_byte && !is_sp;
   assign fnv_mix = run_c_ff ^ chr;

   always_comb begin
      run_a_in  = run_a_ff;
      run_b_in  = run_b_ff;
      run_c_in  = run_c_ff;
      kept_a_in = kept_a_ff;
      kept_b_in = kept_b_ff;
      kept_c_in = kept_c_ff;
      seen_in   = seen_ff;
      if (upd) begin
         run_a_in = (run_a_ff << 5) + run_a_ff + chr;
         run_b_in = (run_b_ff << 5) - run_b_ff + chr;
         run_c_in = fnv_mix * FNV_PRIME;
      end
      if (keep) begin
         kept_a_in = run_a_in;
         kept_b_in = run_b_in;
         kept_c_in = run_c_in;
         seen_in   = 1'b1;
      end
   end

   // Command at key end: {func, pos_c, pos_b, pos_a}
   assign cmd_push = accept && last;
   assign cmd_data = {func, kept_c_in[INDEX_BITS-1:0], kept_b_in[INDEX_BITS-1:0],
                      kept_a_in[INDEX_BITS-1:0]};

   // Key state, back to seeds after each key
   always_ff @(posedge clock) begin
      if (reset || cmd_push) begin
         run_a_ff  <= SEED_A;
         run_b_ff  <= SEED_B;
         run_c_ff  <= SEED_C;
         kept_a_ff <= SEED_A;
         kept_b_ff <= SEED_B;
         kept_c_ff <= SEED_C;
         seen_ff   <= 1'b0;
      end else if (accept) begin
         run_a_ff  <= run_a_in;
         run_b_ff  <= run_b_in;
         run_c_ff  <= run_c_in;
         kept_a_ff <= kept_a_in;
         kept_b_ff <= kept_b_in;
         kept_c_ff <= kept_c_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

>>> rtl/sbf_cmd_fifo.sv
// ----------------------------------------------------------------------------
// sbf_cmd_fifo: short command queue
// Decouples the hash front from the bit engine; head entry shown while
// not empty.
// ----------------------------------------------------------------------------
module sbf_cmd_fifo #(
   parameter int WIDTH = 58
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         head_data,
   output sbf_pkg::fifo_status_type status
);
   import sbf_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);

   logic [WIDTH-1:0] mem_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W:0]   count_ff;

   assign status.full  = (count_ff == (PTR_W+1)'(CMD_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_data    = mem_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/sbf_bit_engine.sv
// ----------------------------------------------------------------------------
// sbf_bit_engine: bit store access and result register
// Clears the store after reset, then per command sets or reads three bits
// through one RAM port and places the result in the output register.
// ----------------------------------------------------------------------------
module sbf_bit_engine #(
   parameter int INDEX_BITS = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sbf_pkg::fifo_status_type cmd_status,
   input  logic [3*INDEX_BITS:0]    cmd_data,
   output logic                     cmd_pop,
   output logic                     clearing,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output logic                     rsp_might_exist,
   output logic                     rsp_was_query,
   output logic [31:0]              rsp_insert_count
);
   import sbf_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_ACCESS = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   localparam logic [1:0] ACC_A = 2'd0;
   localparam logic [1:0] ACC_B = 2'd1;
   localparam logic [1:0] ACC_C = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            acc_ff, acc_in;
   logic [INDEX_BITS-1:0] clr_addr_ff;
   logic [3*INDEX_BITS:0] cmd_ff;
   logic                  hit_ff, hit_in;
   logic [31:0]           total_ff;
   logic                  out_valid_ff;
   logic                  out_hit_ff, out_query_ff;
   logic [31:0]           out_count_ff;
   logic                  cmd_func;
   logic [INDEX_BITS-1:0] acc_addr, ram_addr;
   logic                  ram_wr, ram_rd, ram_rdata;
   logic                  finish_done;
   logic                  load;
   logic                  final_hit;
   logic [31:0]           total_next;

   assign cmd_func = cmd_ff[3*INDEX_BITS];

   // Position of the current access
   always_comb begin
      case (acc_ff)
         ACC_A:   acc_addr = cmd_ff[INDEX_BITS-1:0];
         ACC_B:   acc_addr = cmd_ff[2*INDEX_BITS-1:INDEX_BITS];
         default: acc_addr = cmd_ff[3*INDEX_BITS-1:2*INDEX_BITS];
      endcase
   end

   // RAM port: clear sweep, bit set on insert, bit read on query
   assign clearing = (state_ff == ST_CLEAR);
   assign ram_addr = clearing ? clr_addr_ff : acc_addr;
   assign ram_wr   = clearing || (state_ff == ST_ACCESS && cmd_func == FUNC_INSERT);
   assign ram_rd   = (state_ff == ST_ACCESS) && (cmd_func == FUNC_QUERY);

   sbf_ram #(
      .WIDTH (1),
      .DEPTH (1 << INDEX_BITS)
   ) u_bits (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (ram_addr),
      .wr_data (!clearing),
      .rd_en   (ram_rd),
      .rd_addr (ram_addr),
      .rd_data (ram_rdata)
   );

   // Result completion and counter
   assign finish_done = (state_ff == ST_FINISH) && (!out_valid_ff || rsp_pop);
   assign final_hit   = (cmd_func == FUNC_QUERY) ? (hit_ff & ram_rdata) : 1'b1;
   assign total_next  = (cmd_func == FUNC_INSERT && total_ff != '1) ?
                        total_ff + 32'd1 : total_ff;
   assign load        = !cmd_status.empty &&
                        ((state_ff == ST_IDLE) || finish_done);
   assign cmd_pop     = load;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      hit_in   = hit_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (&clr_addr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (load) begin
               state_in = ST_ACCESS;
               acc_in   = ACC_A;
               hit_in   = 1'b1;
            end
         end
         ST_ACCESS: begin
            if (acc_ff != ACC_A && cmd_func == FUNC_QUERY) begin
               hit_in = hit_ff & ram_rdata;
            end
            acc_in = acc_ff + 2'd1;
            if (acc_ff == ACC_C) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (load) begin
               state_in = ST_ACCESS;
               acc_in   = ACC_A;
               hit_in   = 1'b1;
            end else if (finish_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         acc_ff       <= ACC_A;
         hit_ff       <= 1'b1;
         clr_addr_ff  <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         hit_ff   <= hit_in;
         if (clearing) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
         if (finish_done) begin
            total_ff <= total_next;
         end
         out_valid_ff <= (out_valid_ff && !rsp_pop) || finish_done;
      end
   end

   // Command and result payload
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff <= cmd_data;
      end
      if (finish_done) begin
         out_hit_ff   <= final_hit;
         out_query_ff <= cmd_func;
         out_count_ff <= total_next;
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_might_exist  = out_hit_ff;
   assign rsp_was_query    = out_query_ff;
   assign rsp_insert_count = out_count_ff;

endmodule

>>> rtl/string_bloom_filter_top.sv
// ----------------------------------------------------------------------------
// string_bloom_filter_top: streaming string Bloom filter, three hashes
// Keys arrive one byte per item; at key end three bits are set or tested.
// ----------------------------------------------------------------------------
// Input queue: drive req_* and push while full is low. Each item carries one
// key byte (req_has_byte qualifies it), the operation and a last marker; the
// operation on the last item counts. Bytes are hashed one per cycle.
// Result queue: one item per key, shown while empty is low and taken with
// pop. Insert results always report might_exist = 1.
// Throughput: one byte per cycle in the hash front while full is low; the
// bit engine takes one key at a time, three accesses on the single bit
// store RAM port plus a finishing step. A 4-entry command queue absorbs
// bursts of short keys.
// Reset: a clearing pass writes zero to every one of the 2**INDEX_BITS store
// bits, with full high throughout; the insert counter clears at once.
// Stall: while pop is low the result waits in its register; bytes are
// still hashed and commands queued until the command queue fills, then
// full rises.
// ----------------------------------------------------------------------------
module string_bloom_filter_top #(
   parameter int INDEX_BITS = 19
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_func,
   input  logic [7:0]  req_key_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_might_exist,
   output logic        rsp_was_query,
   output logic [31:0] rsp_insert_count
);
   import sbf_pkg::*;

   localparam int CMD_W = 3*INDEX_BITS + 1;

   fifo_status_type  cmd_status;
   logic             accept;
   logic             clearing;
   logic             cmd_push, cmd_pop;
   logic [CMD_W-1:0] cmd_in, cmd_head;

   assign full   = clearing || cmd_status.full;
   assign accept = push && !full;

   // Front: normalization and hashing
   sbf_hash_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .func     (req_func),
      .key_byte (req_key_byte),
      .has_byte (req_has_byte),
      .last     (req_last),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   // Queue between front and back
   sbf_cmd_fifo #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .pop       (cmd_pop),
      .head_data (cmd_head),
      .status    (cmd_status)
   );

   // Back: bit store and results
   sbf_bit_engine #(
      .INDEX_BITS (INDEX_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .cmd_status       (cmd_status),
      .cmd_data         (cmd_head),
      .cmd_pop          (cmd_pop),
      .clearing         (clearing),
      .rsp_empty        (empty),
      .rsp_pop          (pop),
      .rsp_might_exist  (rsp_might_exist),
      .rsp_was_query    (rsp_was_query),
      .rsp_insert_count (rsp_insert_count)
   );

   // Checks
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_status.full)
      else $error("command pushed into a full queue");

   a_insert_hits: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_was_query) |-> rsp_might_exist)
      else $error("insert result without might_exist");

   a_no_result_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (empty && cmd_status.empty))
      else $error("work present during clearing pass");

endmodule
